// ===== rtl/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg: shared definitions for the nmea sentence framer
// event codes, counter slots and default sizes
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

  localparam int unsigned NAME_MAX         = 5;
  localparam int unsigned LINE_BUFFER_SIZE = 128;
  localparam int unsigned CNT_W            = 16;
  localparam int unsigned NUM_CNT          = 6;
  localparam logic [3:0]  MIN_NAME_RESET   = 4'd5;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_HEADER   = 3'd3,
    EV_NAME     = 3'd4,
    EV_HEX      = 3'd5,
    EV_CR       = 3'd6,
    EV_LF       = 3'd7
  } event_e;

  localparam int unsigned CNT_GOOD   = 0;
  localparam int unsigned CNT_HEADER = 1;
  localparam int unsigned CNT_NAME   = 2;
  localparam int unsigned CNT_CSUM   = 3;
  localparam int unsigned CNT_CR     = 4;
  localparam int unsigned CNT_LF     = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

endpackage

`default_nettype wire

// ===== rtl/nsf_char_if.sv =====
// ----------------------------------------------------------------------------
// nsf_char_if: received character channel
// valid/ready handshake carrying one byte per item
// ----------------------------------------------------------------------------
`default_nettype none

interface nsf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/nsf_event_if.sv =====
// ----------------------------------------------------------------------------
// nsf_event_if: framer event channel
// valid/ready handshake carrying the event code, sentence name and counters
// ----------------------------------------------------------------------------
`default_nettype none

interface nsf_event_if #(
  parameter int unsigned NameMax = nsf_pkg::NAME_MAX
);
  localparam int unsigned NLW = $clog2(NameMax + 1);

  logic                     valid;
  logic                     ready;
  logic [2:0]               event_res;
  logic [8*NameMax-1:0]     name_chars;
  logic [NLW-1:0]           name_length;
  logic [nsf_pkg::CNT_W-1:0] good_count;
  logic [nsf_pkg::CNT_W-1:0] header_errors;
  logic [nsf_pkg::CNT_W-1:0] name_errors;
  logic [nsf_pkg::CNT_W-1:0] checksum_errors;
  logic [nsf_pkg::CNT_W-1:0] cr_errors;
  logic [nsf_pkg::CNT_W-1:0] lf_errors;

  modport source (
    output valid, output event_res, output name_chars, output name_length,
    output good_count, output header_errors, output name_errors,
    output checksum_errors, output cr_errors, output lf_errors,
    input ready
  );
  modport sink (
    input valid, input event_res, input name_chars, input name_length,
    input good_count, input header_errors, input name_errors,
    input checksum_errors, input cr_errors, input lf_errors,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/nmea_sentence_framer.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_framer: nmea 0183 sentence framer and checksum checker
//
// rx_i takes one received byte per item; ev_o gives exactly one event item
// per byte: event code, the sentence name on a good sentence, and six
// wrapping 16-bit event counters. cfg_we_i/cfg_wdata_i write
// min_name_length; the user must write it only while the block is idle,
// which the block itself does not enforce. A byte accepted on rx_i lands in
// an input register, is parsed into the result register when it advances,
// and is shown on ev_o from then on. One byte per cycle is sustained while
// ev_o is ready; the per-byte parse between the input and result registers
// sets that rate. While ev_o is stalled the input register still takes
// one more byte, then rx_i.ready drops until the result is taken.
// Reset (rst_ni low, asynchronous) clears the parser to hunting for '$',
// the checksums and all counters, and sets min_name_length to 5. The name
// bytes are not cleared; only bytes of the current sentence are shown.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer #(
  parameter int unsigned NameMax        = nsf_pkg::NAME_MAX,
  parameter int unsigned LineBufferSize = nsf_pkg::LINE_BUFFER_SIZE
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  nsf_char_if.sink        rx_i,
  nsf_event_if.source     ev_o
);

  localparam int unsigned LW  = $clog2(LineBufferSize);
  localparam int unsigned NLW = $clog2(NameMax + 1);
  localparam int unsigned CW  = nsf_pkg::CNT_W;
  localparam int unsigned NC  = nsf_pkg::NUM_CNT;

  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_NAME = 7'b0000010,
    PH_DATA = 7'b0000100,
    PH_HEX1 = 7'b0001000,
    PH_HEX2 = 7'b0010000,
    PH_CR   = 7'b0100000,
    PH_LF   = 7'b1000000
  } phase_e;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c inside {[8'h30:8'h39], [8'h41:nsf_pkg::CH_UPPER_F]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

  // control and state registers
  logic                 s1_valid_q;
  logic [7:0]           s1_char_q;
  logic                 out_valid_q, out_valid_d;
  phase_e               phase_q, phase_d;
  logic [LW-1:0]        len_q, len_d;
  logic [7:0]           run_q, run_d;
  logic [7:0]           recv_q, recv_d;
  logic [NLW-1:0]       name_cnt_q, name_cnt_d;
  logic [3:0]           min_name_q;
  logic [CW-1:0]        cnt_q [NC];
  logic [NC-1:0]        cnt_inc;
  logic [7:0]           name_mem_q [NameMax];
  logic                 name_we;
  logic [LW-1:0]        name_pos;

  // result registers
  nsf_pkg::event_e      ev_q, ev_d;
  logic [8*NameMax-1:0] sname_q, sname_d;
  logic [NLW-1:0]       slen_q, slen_d;

  logic                 adv;
  logic [LW-1:0]        len_base;
  logic [LW-1:0]        len_inc;
  phase_e               phase_base;

  assign adv        = s1_valid_q && (!out_valid_q || ev_o.ready);
  assign rx_i.ready = !s1_valid_q || adv;

  assign len_base   = (len_q >= LW'(LineBufferSize - 1)) ? '0 : len_q;
  assign phase_base = (len_q >= LW'(LineBufferSize - 1)) ? PH_HUNT : phase_q;
  assign len_inc    = len_base + LW'(1);
  assign name_pos   = len_inc - LW'(2);

  always_comb begin
    phase_d    = phase_base;
    len_d      = len_inc;
    run_d      = run_q;
    recv_d     = recv_q;
    name_cnt_d = name_cnt_q;
    cnt_inc    = '0;
    ev_d       = nsf_pkg::EV_NONE;
    sname_d    = '0;
    slen_d     = '0;
    name_we    = 1'b0;
    case (phase_base)
      PH_NAME: begin
        name_we = (name_pos < LW'(NameMax));
        run_d   = run_q ^ s1_char_q;
        if (is_alnum(s1_char_q)) begin
          if (len_inc > LW'(NameMax + 1)) begin
            ev_d                       = nsf_pkg::EV_NAME;
            cnt_inc[nsf_pkg::CNT_NAME] = 1'b1;
            phase_d                    = PH_HUNT;
            len_d                      = '0;
          end
        end else if (s1_char_q == nsf_pkg::CH_COMMA && name_pos >= LW'(min_name_q)
                     && name_pos <= LW'(NameMax)) begin
          name_cnt_d = NLW'(name_pos);
          phase_d    = PH_DATA;
        end else begin
          ev_d                       = nsf_pkg::EV_NAME;
          cnt_inc[nsf_pkg::CNT_NAME] = 1'b1;
          phase_d                    = PH_HUNT;
          len_d                      = '0;
        end
      end
      PH_DATA: begin
        if (s1_char_q == nsf_pkg::CH_STAR) begin
          phase_d = PH_HEX1;
        end else if (s1_char_q == nsf_pkg::CH_CR) begin
          recv_d  = '0;
          run_d   = '0;
          phase_d = PH_LF;
        end else begin
          run_d = run_q ^ s1_char_q;
        end
      end
      PH_HEX1: begin
        if (is_hex(s1_char_q)) begin
          recv_d  = {hex_val(s1_char_q), 4'h0};
          phase_d = PH_HEX2;
        end else begin
          ev_d                       = nsf_pkg::EV_HEX;
          cnt_inc[nsf_pkg::CNT_CSUM] = 1'b1;
          phase_d                    = PH_HUNT;
          len_d                      = '0;
        end
      end
      PH_HEX2: begin
        if (is_hex(s1_char_q)) begin
          recv_d  = recv_q + {4'h0, hex_val(s1_char_q)};
          phase_d = PH_CR;
        end else begin
          ev_d                       = nsf_pkg::EV_HEX;
          cnt_inc[nsf_pkg::CNT_CSUM] = 1'b1;
          phase_d                    = PH_HUNT;
          len_d                      = '0;
        end
      end
      PH_CR: begin
        if (s1_char_q == nsf_pkg::CH_CR) begin
          phase_d = PH_LF;
        end else begin
          ev_d                     = nsf_pkg::EV_CR;
          cnt_inc[nsf_pkg::CNT_CR] = 1'b1;
          phase_d                  = PH_HUNT;
          len_d                    = '0;
        end
      end
      PH_LF: begin
        phase_d = PH_HUNT;
        len_d   = '0;
        if (s1_char_q == nsf_pkg::CH_LF) begin
          if (run_q == recv_q) begin
            ev_d                       = nsf_pkg::EV_GOOD;
            cnt_inc[nsf_pkg::CNT_GOOD] = 1'b1;
            slen_d                     = name_cnt_q;
            for (int i = 0; i < NameMax; i++) begin
              if (NLW'(i) < name_cnt_q) begin
                sname_d[8*i +: 8] = name_mem_q[i];
              end
            end
          end else begin
            ev_d                       = nsf_pkg::EV_MISMATCH;
            cnt_inc[nsf_pkg::CNT_CSUM] = 1'b1;
          end
        end else begin
          ev_d                     = nsf_pkg::EV_LF;
          cnt_inc[nsf_pkg::CNT_LF] = 1'b1;
        end
      end
      default: begin
        if (s1_char_q == nsf_pkg::CH_DOLLAR) begin
          phase_d = PH_NAME;
          run_d   = '0;
          recv_d  = '0;
        end else begin
          ev_d                         = nsf_pkg::EV_HEADER;
          cnt_inc[nsf_pkg::CNT_HEADER] = 1'b1;
          phase_d                      = PH_HUNT;
          len_d                        = '0;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (ev_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HUNT;
      len_q       <= '0;
      run_q       <= '0;
      recv_q      <= '0;
      name_cnt_q  <= '0;
      min_name_q  <= nsf_pkg::MIN_NAME_RESET;
      for (int i = 0; i < NC; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (cfg_we_i) begin
        min_name_q <= cfg_wdata_i;
      end
      if (adv) begin
        phase_q    <= phase_d;
        len_q      <= len_d;
        run_q      <= run_d;
        recv_q     <= recv_d;
        name_cnt_q <= name_cnt_d;
        for (int i = 0; i < NC; i++) begin
          if (cnt_inc[i]) begin
            cnt_q[i] <= cnt_q[i] + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_char_q <= rx_i.rx_char;
    end
    if (adv) begin
      ev_q    <= ev_d;
      sname_q <= sname_d;
      slen_q  <= slen_d;
    end
    if (adv && name_we) begin
      name_mem_q[name_pos[$clog2(NameMax)-1:0]] <= s1_char_q;
    end
  end

  assign ev_o.valid           = out_valid_q;
  assign ev_o.event_res       = ev_q;
  assign ev_o.name_chars      = sname_q;
  assign ev_o.name_length     = slen_q;
  assign ev_o.good_count      = cnt_q[nsf_pkg::CNT_GOOD];
  assign ev_o.header_errors   = cnt_q[nsf_pkg::CNT_HEADER];
  assign ev_o.name_errors     = cnt_q[nsf_pkg::CNT_NAME];
  assign ev_o.checksum_errors = cnt_q[nsf_pkg::CNT_CSUM];
  assign ev_o.cr_errors       = cnt_q[nsf_pkg::CNT_CR];
  assign ev_o.lf_errors       = cnt_q[nsf_pkg::CNT_LF];

endmodule

`default_nettype wire

// ===== rtl/nsf_checker.sv =====
// ----------------------------------------------------------------------------
// nsf_checker: port-level checks for the nmea sentence framer
// watches the event channel and counters over time
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_checker #(
  parameter int unsigned NameMax = nsf_pkg::NAME_MAX
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              ev_valid_i,
  input wire logic                              ev_ready_i,
  input wire logic [2:0]                        event_res_i,
  input wire logic [8*NameMax-1:0]              name_chars_i,
  input wire logic [$clog2(NameMax+1)-1:0]      name_length_i,
  input wire logic [nsf_pkg::CNT_W-1:0]         good_count_i,
  input wire logic [nsf_pkg::CNT_W-1:0]         header_errors_i
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && !ev_ready_i |=> ev_valid_i && $stable(event_res_i)
      && $stable(name_chars_i) && $stable(good_count_i))
    else $error("event item changed while stalled");

  // name only reported with a good sentence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && event_res_i != nsf_pkg::EV_GOOD |->
      name_chars_i == '0 && name_length_i == '0)
    else $error("name shown without good sentence");

  // name length bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_i && event_res_i == nsf_pkg::EV_GOOD |->
      name_length_i <= ($clog2(NameMax+1))'(NameMax))
    else $error("name length out of range");

  // good counter steps only with a good sentence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && good_count_i != $past(good_count_i) |->
      event_res_i == nsf_pkg::EV_GOOD && ev_valid_i
      && good_count_i == $past(good_count_i) + nsf_pkg::CNT_W'(1))
    else $error("good count moved without good sentence");

  // header counter steps only with a header error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && header_errors_i != $past(header_errors_i) |->
      event_res_i == nsf_pkg::EV_HEADER && ev_valid_i)
    else $error("header count moved without header error");

endmodule

bind nmea_sentence_framer nsf_checker #(
  .NameMax (NameMax)
) u_nsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .ev_valid_i      (ev_o.valid),
  .ev_ready_i      (ev_o.ready),
  .event_res_i     (ev_o.event_res),
  .name_chars_i    (ev_o.name_chars),
  .name_length_i   (ev_o.name_length),
  .good_count_i    (ev_o.good_count),
  .header_errors_i (ev_o.header_errors)
);

`default_nettype wire
